// ----- sv/i2chs_pkg.sv -----
`default_nettype none

package i2chs_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT    = 1'd1;

  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'd136;
  localparam logic [15:0] ACK_TIMEOUT_RST    = 16'd255;

  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] READ_BIT = 8'h01;

  // Scale factors of the unit conversion.
  localparam logic [15:0] TEMP_SPAN   = 16'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [15:0] HUM_SPAN    = 16'd10000;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_START = 5'd1,
    PH_SEND  = 5'd2,
    PH_WACK  = 5'd3,
    PH_READ  = 5'd4,
    PH_MACK  = 5'd5,
    PH_STOP  = 5'd6
  } phase_t;

  typedef struct packed {
    logic       scl_in;
    logic       sda_in;
    logic [7:0] cmd_lsb;
    logic [7:0] cmd_msb;
    logic [1:0] func;
  } in_item_t;

  typedef struct packed {
    logic [15:0] hum_raw;
    logic [15:0] temp_raw;
    logic        no_ack;
    logic        done_res;
    logic        busy_res;
    logic        sda_out;
    logic        scl_out;
  } step_res_t;

endpackage

`default_nettype wire

// ----- sv/i2chs_ctrl.sv -----
`default_nettype none

module i2chs_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       step_en,
  input  wire i2chs_pkg::in_item_t  item,
  input  wire [7:0]                 device_address,
  input  wire [15:0]                ack_timeout,
  output i2chs_pkg::step_res_t      res
);
  import i2chs_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  half_r, half_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [2:0]  byte_r, byte_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic [15:0] hum_r, hum_nxt;
  logic        fail_r, fail_nxt;
  logic        rd_r, rd_nxt;

  logic [3:0]  bit_inc;
  logic [2:0]  byte_inc;
  logic [7:0]  rx_byte;
  logic        done;
  logic        scl_o, sda_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      half_r  <= '0;
      bit_r   <= '0;
      byte_r  <= '0;
      shift_r <= '0;
      wait_r  <= '0;
      cmd_r   <= '0;
      temp_r  <= '0;
      hum_r   <= '0;
      fail_r  <= 1'b0;
      rd_r    <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      half_r  <= half_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      wait_r  <= wait_nxt;
      cmd_r   <= cmd_nxt;
      temp_r  <= temp_nxt;
      hum_r   <= hum_nxt;
      fail_r  <= fail_nxt;
      rd_r    <= rd_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    half_nxt  = half_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    shift_nxt = shift_r;
    wait_nxt  = wait_r;
    cmd_nxt   = cmd_r;
    temp_nxt  = temp_r;
    hum_nxt   = hum_r;
    fail_nxt  = fail_r;
    rd_nxt    = rd_r;
    done      = 1'b0;
    bit_inc   = bit_r + 4'd1;
    byte_inc  = byte_r + 3'd1;
    rx_byte   = {shift_r[6:0], item.sda_in};

    unique case (phase_r)
      PH_IDLE: begin
        if (item.func == FUNC_WRITE || item.func == FUNC_READ) begin
          rd_nxt = (item.func == FUNC_READ);
          if (item.func == FUNC_WRITE) begin
            cmd_nxt = {item.cmd_msb, item.cmd_lsb};
          end
          fail_nxt  = 1'b0;
          byte_nxt  = '0;
          bit_nxt   = '0;
          shift_nxt = (item.func == FUNC_READ) ? (device_address | READ_BIT) : device_address;
          phase_nxt = PH_START;
          half_nxt  = '0;
        end
      end
      PH_START: begin
        bit_nxt   = '0;
        phase_nxt = PH_SEND;
        half_nxt  = '0;
      end
      PH_SEND: begin
        if (half_r == 2'd0) begin
          half_nxt = 2'd1;
        end else if (item.scl_in) begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_inc;
          if (bit_inc >= 4'd8) begin
            bit_nxt   = '0;
            wait_nxt  = '0;
            phase_nxt = PH_WACK;
            half_nxt  = '0;
          end else begin
            half_nxt = 2'd0;
          end
        end
      end
      PH_WACK: begin
        if (half_r == 2'd0) begin
          half_nxt = 2'd1;
        end else if (item.scl_in) begin
          if (!item.sda_in) begin
            wait_nxt = '0;
            half_nxt = '0;
            if (rd_r) begin
              byte_nxt  = '0;
              bit_nxt   = '0;
              shift_nxt = '0;
              phase_nxt = PH_READ;
            end else begin
              byte_nxt = byte_inc;
              if (byte_inc == 3'd1) begin
                shift_nxt = cmd_r[15:8];
                phase_nxt = PH_SEND;
              end else if (byte_inc == 3'd2) begin
                shift_nxt = cmd_r[7:0];
                phase_nxt = PH_SEND;
              end else begin
                phase_nxt = PH_STOP;
              end
            end
          end else if (wait_r >= ack_timeout) begin
            fail_nxt  = 1'b1;
            temp_nxt  = '0;
            hum_nxt   = '0;
            phase_nxt = PH_STOP;
            half_nxt  = '0;
          end else begin
            wait_nxt = wait_r + 16'd1;
          end
        end
      end
      PH_READ: begin
        if (half_r == 2'd0) begin
          half_nxt = 2'd1;
        end else if (item.scl_in) begin
          shift_nxt = rx_byte;
          bit_nxt   = bit_inc;
          if (bit_inc >= 4'd8) begin
            bit_nxt = '0;
            // Bytes two and five carry CRC and are dropped.
            case (byte_r)
              3'd0:    temp_nxt = {rx_byte, temp_r[7:0]};
              3'd1:    temp_nxt = {temp_r[15:8], rx_byte};
              3'd3:    hum_nxt  = {rx_byte, hum_r[7:0]};
              3'd4:    hum_nxt  = {hum_r[15:8], rx_byte};
              default: ;
            endcase
            phase_nxt = PH_MACK;
            half_nxt  = '0;
          end else begin
            half_nxt = 2'd0;
          end
        end
      end
      PH_MACK: begin
        if (half_r == 2'd0) begin
          half_nxt = 2'd1;
        end else if (item.scl_in) begin
          half_nxt = '0;
          if (byte_r >= 3'd5) begin
            phase_nxt = PH_STOP;
          end else begin
            byte_nxt  = byte_inc;
            shift_nxt = '0;
            phase_nxt = PH_READ;
          end
        end
      end
      PH_STOP: begin
        if (half_r == 2'd0) begin
          half_nxt = 2'd1;
        end else if (half_r == 2'd1) begin
          if (item.scl_in) begin
            half_nxt = 2'd2;
          end
        end else begin
          phase_nxt = PH_IDLE;
          half_nxt  = '0;
          done      = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        half_nxt  = '0;
      end
    endcase

    // Line drives follow the state after this tick.
    scl_o = 1'b1;
    sda_o = 1'b1;
    unique case (phase_nxt)
      PH_START: begin
        sda_o = 1'b0;
      end
      PH_SEND: begin
        scl_o = half_nxt[0];
        sda_o = shift_nxt[7];
      end
      PH_WACK, PH_READ: begin
        scl_o = half_nxt[0];
      end
      PH_MACK: begin
        scl_o = half_nxt[0];
        sda_o = (byte_nxt >= 3'd5);
      end
      PH_STOP: begin
        scl_o = (half_nxt != 2'd0);
        sda_o = (half_nxt == 2'd2);
      end
      default: ;
    endcase

    res.scl_out  = scl_o;
    res.sda_out  = sda_o;
    res.busy_res = (phase_nxt != PH_IDLE);
    res.done_res = done;
    res.no_ack   = fail_nxt;
    res.temp_raw = temp_nxt;
    res.hum_raw  = hum_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/i2chs_conv.sv -----
`default_nettype none

module i2chs_conv (
  input  wire        [15:0] temp_raw,
  input  wire        [15:0] hum_raw,
  output logic signed [14:0] temp_centi,
  output logic        [13:0] hum_centi
);
  import i2chs_pkg::*;

  logic [31:0] t_sum, h_sum;
  logic [31:0] t_quo, h_quo;
  logic [14:0] t_q;

  // Division by 65535: with y = x + 1, floor(x / 65535) equals
  // (y + (y >> 16)) >> 16 for every product of two 16-bit factors.
  always_comb begin
    t_sum      = 32'(temp_raw) * 32'(TEMP_SPAN) + 32'd1;
    h_sum      = 32'(hum_raw) * 32'(HUM_SPAN) + 32'd1;
    t_quo      = (t_sum + (t_sum >> 16)) >> 16;
    h_quo      = (h_sum + (h_sum >> 16)) >> 16;
    t_q        = t_quo[14:0];
    temp_centi = signed'(t_q - TEMP_OFFSET);
    hum_centi  = h_quo[13:0];
  end

endmodule

`default_nettype wire

// ----- sv/i2c_humidity_sensor_reader.sv -----
`default_nettype none

// I2C master for a temperature and humidity sensor, driven by bus ticks.
// Every word on the in_ channel is one half-bit tick: the sampled SDA and SCL
// levels plus an optional command (write two command bytes, or read one
// measurement). Every input word yields exactly one word on the out_ channel
// with the SCL and SDA drives for the next half bit, busy, done and no_ack
// flags, the raw words and the converted readings in hundredths.
// The cfg_ channel sets the device address and the acknowledge timeout; it
// is always ready and should only be written while no transaction runs.
// From input acceptance to out_tvalid a word passes an input register, the
// bus state machine feeding a step register, then the unit conversion (a
// constant multiply per reading and a reciprocal correction) feeding the
// output register. Throughput is one word per cycle while out_tready stays
// high, set by the state machine advancing once per accepted word.
// When out_tready is low the stages fill up and in_tready drops once all three
// registers hold words; nothing is lost or repeated.
// Synchronous reset returns the bus machine to idle with released lines,
// clears the readings and loads the default address and timeout.
module i2c_humidity_sensor_reader (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // {pad[3:0], scl_in, sda_in, cmd_lsb[7:0], cmd_msb[7:0], func[1:0]}
  input  wire [i2chs_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // {pad[5:0], hum_centi[13:0], temp_centi[14:0], hum_raw[15:0],
  //  temp_raw[15:0], no_ack, done_res, busy_res, sda_out, scl_out}
  output logic [i2chs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  input  wire [i2chs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [i2chs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready
);
  import i2chs_pkg::*;

  logic [7:0]  dev_addr_r;
  logic [15:0] ack_tmo_r;

  logic        a_valid_r;
  in_item_t    a_item_r;
  logic        b_valid_r;
  step_res_t   b_res_r;
  logic        c_valid_r;
  step_res_t   c_res_r;
  logic signed [14:0] c_temp_centi_r;
  logic [13:0] c_hum_centi_r;

  logic        en_a, en_b, en_c;
  logic        step_en;
  step_res_t   step_res;
  logic signed [14:0] temp_centi;
  logic [13:0] hum_centi;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEVICE_ADDRESS_RST;
      ack_tmo_r  <= ACK_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS: dev_addr_r <= cfg_data[7:0];
        REG_ACK_TIMEOUT:    ack_tmo_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage loads when it is empty or its word moves on.
  assign en_c      = !c_valid_r || out_tready;
  assign en_b      = !b_valid_r || en_c;
  assign en_a      = !a_valid_r || en_b;
  assign in_tready = en_a;
  assign step_en   = a_valid_r && en_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (en_a) a_valid_r <= in_tvalid;
      if (en_b) b_valid_r <= a_valid_r;
      if (en_c) c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_tvalid) begin
      a_item_r <= in_item_t'(in_tdata[$bits(in_item_t)-1:0]);
    end
    if (step_en) begin
      b_res_r <= step_res;
    end
    if (en_c && b_valid_r) begin
      c_res_r        <= b_res_r;
      c_temp_centi_r <= temp_centi;
      c_hum_centi_r  <= hum_centi;
    end
  end

  i2chs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .item           (a_item_r),
    .device_address (dev_addr_r),
    .ack_timeout    (ack_tmo_r),
    .res            (step_res)
  );

  i2chs_conv u_conv (
    .temp_raw   (b_res_r.temp_raw),
    .hum_raw    (b_res_r.hum_raw),
    .temp_centi (temp_centi),
    .hum_centi  (hum_centi)
  );

  assign out_tvalid = c_valid_r;
  assign out_tdata  = {6'd0, c_hum_centi_r, c_temp_centi_r, c_res_r};

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !b_valid_r)
    else $error("pipeline not empty after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && c_res_r.done_res |-> !c_res_r.busy_res)
    else $error("done reported while still busy");

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !c_res_r.busy_res |-> c_res_r.scl_out && c_res_r.sda_out)
    else $error("bus lines driven while idle");

  a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> b_valid_r)
    else $error("bus step taken without a result word");
`endif

endmodule

`default_nettype wire

// ----- test/sensor_bus_monitor.sv -----
`timescale 1ns / 1ps

// Watches all three channels of the sensor reader. It keeps its own copy of
// the bus state machine and the two registers, predicts one result word per
// accepted tick word, and compares each result field by field.
module sensor_bus_monitor (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire [i2chs_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire                               in_tvalid,
  input  wire                               in_tready,
  input  wire [i2chs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire                               out_tvalid,
  input  wire                               out_tready,
  input  wire [i2chs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [i2chs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                               cfg_valid,
  input  wire                               cfg_ready,
  output int                                errors,
  output int                                pending,
  output int                                checked
);
  import i2chs_pkg::*;

  typedef struct packed {
    logic [5:0]  pad;
    logic [13:0] hum_centi;
    logic [14:0] temp_centi;
    step_res_t   step;
  } sensor_word_t;

  sensor_word_t due_words[$];

  logic [7:0]  addr_byte;
  logic [15:0] ack_limit;

  phase_t      bus_phase;
  logic [1:0]  half;
  logic [3:0]  bit_cnt;
  logic [2:0]  byte_idx;
  logic [7:0]  shreg;
  logic [15:0] waited;
  logic [15:0] cmd_word;
  logic [15:0] temp_word;
  logic [15:0] hum_word;
  logic        failed;
  logic        rd_mode;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  function automatic void enter_phase(input phase_t ph);
    bus_phase = ph;
    half      = 2'd0;
  endfunction

  // Advances the bus machine by one half-bit tick and builds the word the
  // block should emit for it.
  task automatic advance_bus(input in_item_t it, output sensor_word_t w);
    logic        done;
    logic [31:0] scaled;
    done = 1'b0;
    case (bus_phase)
      PH_IDLE: begin
        if (it.func == FUNC_WRITE || it.func == FUNC_READ) begin
          rd_mode = (it.func == FUNC_READ);
          if (!rd_mode) cmd_word = {it.cmd_msb, it.cmd_lsb};
          failed   = 1'b0;
          byte_idx = 3'd0;
          bit_cnt  = 4'd0;
          shreg    = rd_mode ? (addr_byte | READ_BIT) : addr_byte;
          enter_phase(PH_START);
        end
      end
      PH_START: begin
        bit_cnt = 4'd0;
        enter_phase(PH_SEND);
      end
      PH_SEND: begin
        if (half == 2'd0) begin
          half = 2'd1;
        end else if (it.scl_in) begin
          shreg   = shreg << 1;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            bit_cnt = 4'd0;
            waited  = 16'd0;
            enter_phase(PH_WACK);
          end else begin
            half = 2'd0;
          end
        end
      end
      PH_WACK: begin
        if (half == 2'd0) begin
          half = 2'd1;
        end else if (it.scl_in) begin
          if (!it.sda_in) begin
            waited = 16'd0;
            if (rd_mode) begin
              byte_idx = 3'd0;
              bit_cnt  = 4'd0;
              shreg    = 8'd0;
              enter_phase(PH_READ);
            end else begin
              byte_idx = byte_idx + 3'd1;
              if (byte_idx == 3'd1) begin
                shreg = cmd_word[15:8];
                enter_phase(PH_SEND);
              end else if (byte_idx == 3'd2) begin
                shreg = cmd_word[7:0];
                enter_phase(PH_SEND);
              end else begin
                enter_phase(PH_STOP);
              end
            end
          end else if (waited >= ack_limit) begin
            failed    = 1'b1;
            temp_word = 16'd0;
            hum_word  = 16'd0;
            enter_phase(PH_STOP);
          end else begin
            waited = waited + 16'd1;
          end
        end
      end
      PH_READ: begin
        if (half == 2'd0) begin
          half = 2'd1;
        end else if (it.scl_in) begin
          shreg   = {shreg[6:0], it.sda_in};
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            bit_cnt = 4'd0;
            // Bytes 2 and 5 carry the checksums and are dropped.
            case (byte_idx)
              3'd0: temp_word[15:8] = shreg;
              3'd1: temp_word[7:0]  = shreg;
              3'd3: hum_word[15:8]  = shreg;
              3'd4: hum_word[7:0]   = shreg;
              default: ;
            endcase
            enter_phase(PH_MACK);
          end else begin
            half = 2'd0;
          end
        end
      end
      PH_MACK: begin
        if (half == 2'd0) begin
          half = 2'd1;
        end else if (it.scl_in) begin
          if (byte_idx >= 3'd5) begin
            enter_phase(PH_STOP);
          end else begin
            byte_idx = byte_idx + 3'd1;
            shreg    = 8'd0;
            enter_phase(PH_READ);
          end
        end
      end
      PH_STOP: begin
        if (half == 2'd0) begin
          half = 2'd1;
        end else if (half == 2'd1) begin
          if (it.scl_in) half = 2'd2;
        end else begin
          enter_phase(PH_IDLE);
          done = 1'b1;
        end
      end
      default: enter_phase(PH_IDLE);
    endcase

    w = '0;
    w.step.scl_out = 1'b1;
    w.step.sda_out = 1'b1;
    case (bus_phase)
      PH_START: w.step.sda_out = 1'b0;
      PH_SEND: begin
        w.step.scl_out = half[0];
        w.step.sda_out = shreg[7];
      end
      PH_WACK, PH_READ: w.step.scl_out = half[0];
      PH_MACK: begin
        w.step.scl_out = half[0];
        w.step.sda_out = (byte_idx >= 3'd5);
      end
      PH_STOP: begin
        w.step.scl_out = (half != 2'd0);
        w.step.sda_out = (half == 2'd2);
      end
      default: ;
    endcase
    w.step.busy_res = (bus_phase != PH_IDLE);
    w.step.done_res = done;
    w.step.no_ack   = failed;
    w.step.temp_raw = temp_word;
    w.step.hum_raw  = hum_word;
    scaled       = (32'(TEMP_SPAN) * 32'(temp_word)) / 32'd65535;
    w.temp_centi = 15'(scaled - 32'(TEMP_OFFSET));
    scaled       = (32'(HUM_SPAN) * 32'(hum_word)) / 32'd65535;
    w.hum_centi  = 14'(scaled);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 30)
      $display("%0t ns: word %0d %s is %0h, predicted %0h", $realtime, checked, what,
               got, want);
    errors = errors + 1;
  endtask

  always @(posedge clk) begin
    sensor_word_t w;
    sensor_word_t got;
    if (!rst_n) begin
      addr_byte = DEVICE_ADDRESS_RST;
      ack_limit = ACK_TIMEOUT_RST;
      bus_phase = PH_IDLE;
      half      = 2'd0;
      bit_cnt   = 4'd0;
      byte_idx  = 3'd0;
      shreg     = 8'd0;
      waited    = 16'd0;
      cmd_word  = 16'd0;
      temp_word = 16'd0;
      hum_word  = 16'd0;
      failed    = 1'b0;
      rd_mode   = 1'b0;
      due_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEVICE_ADDRESS: addr_byte = cfg_data[7:0];
          REG_ACK_TIMEOUT:    ack_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        advance_bus(in_item_t'(in_tdata[$bits(in_item_t)-1:0]), w);
        due_words.push_back(w);
      end
      if (out_tvalid && out_tready) begin
        got = sensor_word_t'(out_tdata);
        if (due_words.size() == 0) begin
          report_mismatch("arrived with nothing outstanding", got[31:0], 32'd0);
        end else begin
          w = due_words.pop_front();
          if (got.step.scl_out !== w.step.scl_out)
            report_mismatch("scl_out", 32'(got.step.scl_out), 32'(w.step.scl_out));
          if (got.step.sda_out !== w.step.sda_out)
            report_mismatch("sda_out", 32'(got.step.sda_out), 32'(w.step.sda_out));
          if (got.step.busy_res !== w.step.busy_res)
            report_mismatch("busy_res", 32'(got.step.busy_res), 32'(w.step.busy_res));
          if (got.step.done_res !== w.step.done_res)
            report_mismatch("done_res", 32'(got.step.done_res), 32'(w.step.done_res));
          if (got.step.no_ack !== w.step.no_ack)
            report_mismatch("no_ack", 32'(got.step.no_ack), 32'(w.step.no_ack));
          if (got.step.temp_raw !== w.step.temp_raw)
            report_mismatch("temp_raw", 32'(got.step.temp_raw), 32'(w.step.temp_raw));
          if (got.step.hum_raw !== w.step.hum_raw)
            report_mismatch("hum_raw", 32'(got.step.hum_raw), 32'(w.step.hum_raw));
          if (got.temp_centi !== w.temp_centi)
            report_mismatch("temp_centi", 32'(got.temp_centi), 32'(w.temp_centi));
          if (got.hum_centi !== w.hum_centi)
            report_mismatch("hum_centi", 32'(got.hum_centi), 32'(w.hum_centi));
        end
        checked = checked + 1;
      end
    end
    pending <= due_words.size();
  end

endmodule

// ----- test/i2c_humidity_sensor_reader_test.sv -----
`timescale 1ns / 1ps

module i2c_humidity_sensor_reader_test;
  import i2chs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_TICKS = 240;

  localparam logic [1:0] FUNC_NONE  = 2'd0;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic                    clk;
  logic                    rst_n;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    cfg_valid;
  logic                    cfg_ready;

  int          errors;
  int          pending;
  int          checked;
  int          cycle_count = 0;
  bit          hold_off_req;
  int          burst_left;
  int          tick_total;
  int          reads_run;
  int          writes_run;
  int          ack_timeouts;
  logic [15:0] cur_timeout;

  i2c_humidity_sensor_reader dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  sensor_bus_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: spans of random length, each with its own readiness level,
  // plus a long hold-off whenever the stimulus asks for one.
  initial begin
    int span_left;
    int mode;
    int held;
    out_tready = 1'b0;
    span_left  = 0;
    mode       = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        held = 0;
        out_tready <= 1'b0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end
      if (span_left == 0) begin
        mode      = $urandom_range(0, 3);
        span_left = $urandom_range(8, 80);
      end
      span_left--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // One tick word; the sender works in bursts with random gaps between them.
  task automatic push_tick(input logic [1:0] func, input logic [7:0] msb,
                           input logic [7:0] lsb, input logic sda, input logic scl);
    in_item_t item;
    int       gap;
    item.func    = func;
    item.cmd_msb = msb;
    item.cmd_lsb = lsb;
    item.sda_in  = sda;
    item.scl_in  = scl;
    in_tdata  <= IN_TDATA_W'(item);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tick_total++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // A tick during a transaction. Now and then it carries a command, which a
  // busy master must ignore.
  task automatic bus_tick(input logic sda, input logic scl);
    logic [1:0] func;
    func = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(1, 3)) : FUNC_NONE;
    push_tick(func, 8'($urandom), 8'($urandom), sda, scl);
  endtask

  task automatic low_half();
    bus_tick(1'($urandom), 1'($urandom));
  endtask

  // The slave may stretch the clock for a few ticks before SCL rises.
  task automatic high_half(input logic sda_bit);
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 4)) bus_tick(1'($urandom), 1'b0);
    bus_tick(sda_bit, 1'b1);
  endtask

  task automatic send_bits();
    repeat (8) begin
      low_half();
      high_half(1'($urandom));
    end
  endtask

  task automatic wait_ack(input int delay, output bit acked);
    int highs;
    low_half();
    acked = (delay <= int'(cur_timeout));
    highs = acked ? delay : int'(cur_timeout) + 1;
    repeat (highs) high_half(1'b1);
    if (acked) high_half(1'b0);
    else ack_timeouts++;
  endtask

  task automatic finish_stop();
    low_half();
    high_half(1'($urandom));
    low_half();
  endtask

  function automatic int pick_ack_delay();
    if (cur_timeout <= 16'd40 && $urandom_range(0, 3) == 0)
      return int'(cur_timeout) + int'($urandom_range(0, 2)) - 1;
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0;
  endfunction

  // data holds the six bytes the sensor returns, first byte in the top bits.
  task automatic read_measurement(input logic [47:0] data, input int delay);
    bit         acked;
    logic [7:0] rx;
    reads_run++;
    push_tick(FUNC_READ, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    bus_tick(1'($urandom), 1'($urandom));
    send_bits();
    wait_ack(delay, acked);
    if (acked) begin
      for (int b = 0; b < 6; b++) begin
        rx = data[47 - 8*b -: 8];
        for (int i = 7; i >= 0; i--) begin
          low_half();
          high_half(rx[i]);
        end
        low_half();
        high_half(1'($urandom));
      end
    end
    finish_stop();
  endtask

  task automatic write_command(input logic [7:0] msb, input logic [7:0] lsb,
                               input int d0, input int d1, input int d2);
    bit acked;
    int delays[3];
    delays = '{d0, d1, d2};
    writes_run++;
    push_tick(FUNC_WRITE, msb, lsb, 1'($urandom), 1'($urandom));
    bus_tick(1'($urandom), 1'($urandom));
    for (int k = 0; k < 3; k++) begin
      send_bits();
      wait_ack(delays[k], acked);
      if (!acked) break;
    end
    finish_stop();
  endtask

  // Garbage on the bus or a transaction cut short, then plain ticks with
  // mostly low SDA so the master runs back to idle.
  task automatic disturb_bus();
    if ($urandom_range(0, 1) == 0) begin
      push_tick(2'($urandom_range(1, 2)), 8'($urandom), 8'($urandom), 1'($urandom),
                1'($urandom));
      repeat ($urandom_range(1, 60))
        push_tick(FUNC_NONE, 8'($urandom), 8'($urandom), 1'($urandom), 1'b1);
    end else begin
      repeat ($urandom_range(1, 40))
        push_tick(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    end
    repeat (DRAIN_TICKS)
      push_tick(FUNC_NONE, 8'($urandom), 8'($urandom), ($urandom_range(0, 3) == 0),
                ($urandom_range(0, 7) != 0));
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ACK_TIMEOUT) cur_timeout = value;
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [15:0] timeout);
    quiesce();
    write_reg(REG_DEVICE_ADDRESS, {8'd0, addr});
    write_reg(REG_ACK_TIMEOUT, timeout);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0]  addrs[4];
    logic [15:0] limits[4];
    int          phase_start;
    int          pick;
    rst_n        = 1'b0;
    in_tdata     = '0;
    in_tvalid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cfg_valid    = 1'b0;
    hold_off_req = 1'b0;
    burst_left   = 1;
    tick_total   = 0;
    reads_run    = 0;
    writes_run   = 0;
    ack_timeouts = 0;
    cur_timeout  = ACK_TIMEOUT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset configuration.
    push_tick(FUNC_SPARE, 8'hFF, 8'hFF, 1'b1, 1'b1);
    push_tick(FUNC_NONE, 8'h00, 8'h00, 1'b0, 1'b0);
    hold_off_req = 1'b1;
    read_measurement(48'hFFFF_FFFF_FFFF, 0);
    read_measurement(48'h0000_0000_0000, 1);
    write_command(8'hFF, 8'h00, 0, 2, 0);
    // An acknowledge on the last tolerated high sample, then one sample late.
    write_command(8'h00, 8'hFF, 0, 255, 0);
    read_measurement(48'h6666_5A80_00C3, 256);
    quiesce();

    addrs  = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    limits = '{16'd1, 16'hFFFF, 16'($urandom_range(2, 24)), 16'($urandom_range(25, 300))};
    for (int s = 0; s < 4; s++) begin
      set_config(addrs[s], limits[s]);
      phase_start = tick_total;
      while (tick_total - phase_start < 40) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          read_measurement(48'({$urandom, $urandom}), pick_ack_delay());
        end else if (pick < 15) begin
          write_command(8'($urandom), 8'($urandom), pick_ack_delay(), pick_ack_delay(),
                        pick_ack_delay());
        end else if (pick < 18) begin
          disturb_bus();
        end else begin
          hold_off_req = 1'b1;
          read_measurement(48'({$urandom, $urandom}), pick_ack_delay());
        end
      end
    end

    quiesce();
    repeat (10) @(posedge clk);
    $display("Sent %0d bus ticks: %0d measurement reads, %0d command writes, %0d ack timeouts.",
             tick_total, reads_run, writes_run, ack_timeouts);
    $display("Compared %0d result words over five register settings.", checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
